// ----- sv/sample_statistics_engine_core_macros.svh -----
// Assertion macros for the sample statistics engine.
// Included by the top level; expects signals clk and rst in scope.
`ifndef SAMPLE_STATISTICS_ENGINE_CORE_MACROS_SVH
`define SAMPLE_STATISTICS_ENGINE_CORE_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define SSEC_ASSERT_HOLDS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define SSEC_ASSERT_IMPLIES(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// A condition that implies another in the next cycle.
`define SSEC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- sv/ssec_pkg.sv -----
// Shared constants and types for the sample statistics engine.
// No dependencies; used by the divider, the root unit and the top level.
`default_nettype none

package ssec_pkg;

  // Data format.
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_COUNT   = 65536;

  // Accumulator widths.
  localparam int CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int MAG_W  = SUM_W - 1;

  // Shared multiplier.
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SQ_LO_W  = 24;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;

  // Final division: n*Q - S*S over n*(n-1), scaled by two fraction widths.
  localparam int D_W        = 63;
  localparam int DEN_W      = 2 * CNT_W - 1;
  localparam int NUM_W      = D_W + 2 * FRAC_BITS;
  localparam int MEAN_NUM_W = MAG_W + FRAC_BITS;
  localparam int ITER_W     = $clog2(NUM_W + 1);

  // Result widths.
  localparam int MEAN_W = 24;
  localparam int VAR_W  = 39;
  localparam int QV_W   = 48;
  localparam int ROOT_W = QV_W / 2;
  localparam int ROOT_ITER_W = $clog2(ROOT_W + 1);

  // Status of an iterative unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ----- sv/ssec_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the mean and variance.
// Depends on ssec_pkg for widths and the unit status type.
`default_nettype none

module ssec_div import ssec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ITER_W-1:0] iters,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  output unit_stat_t        stat,
  output logic [NUM_W-1:0]  quot,
  output logic [DEN_W-1:0]  rem
);

  logic [DEN_W-1:0]  den_r;
  logic [ITER_W-1:0] cnt;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              take;

  // Shift the next numerator bit into the partial remainder and try the divisor.
  assign trial = {rem, quot[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign take  = (trial >= {1'b0, den_r});

  // The quotient bits shift into the numerator register from the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= iters;
        quot      <= num;
        rem       <= '0;
        den_r     <= den;
      end else if (stat.busy) begin
        quot <= {quot[NUM_W-2:0], take};
        rem  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == ITER_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/ssec_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on ssec_pkg for widths and the unit status type.
`default_nettype none

module ssec_sqrt import ssec_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [QV_W-1:0]   x,
  output unit_stat_t        stat,
  output logic [ROOT_W-1:0] root
);

  logic [QV_W-1:0]        xr;
  logic [ROOT_W+1:0]      rem;
  logic [ROOT_ITER_W-1:0] cnt;
  logic [ROOT_W+3:0]      trial_rem;
  logic [ROOT_W+3:0]      trial;
  logic [ROOT_W+3:0]      diff;
  logic                   take;

  // Bring down the next two radicand bits and try 4*root + 1.
  assign trial_rem = {rem, xr[QV_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign diff      = trial_rem - trial;
  assign take      = (trial_rem >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= ROOT_ITER_W'(ROOT_W);
        xr        <= x;
        rem       <= '0;
        root      <= '0;
      end else if (stat.busy) begin
        xr   <= {xr[QV_W-3:0], 2'b00};
        rem  <= take ? diff[ROOT_W+1:0] : trial_rem[ROOT_W+1:0];
        root <= {root[ROOT_W-2:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == ROOT_ITER_W'(1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/sample_statistics_engine_core.sv -----
// Sample statistics engine: count, mean, variance, standard deviation, max and min.
// Samples are taken one per cycle while the engine accumulates; a word with tlast closes the
// set, after which the input is held off until the result word is loaded, longer while the
// previous result word waits. The hold-off covers the one-bit-per-cycle divider (40 steps
// for the mean, 79 for the variance) and the 24-step root unit; a single sample skips the
// variance and the root. Synchronous active-high reset clears all sets in progress.
// The finished result sits in an output register while the next set streams in.
`default_nettype none

`include "sample_statistics_engine_core_macros.svh"

module sample_statistics_engine_core import ssec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [15:0] sample
  input  logic         s_tlast,   // last
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata    // [16:0] sample_count, [40:17] mean_q8,
                                  // [79:41] variance_q8, [103:80] stddev_q8,
                                  // [119:104] max_value, [135:120] min_value,
                                  // [136] overflow, rest zero
);

  // Sequencer states.
  localparam logic [2:0] ST_ACC   = 3'd0;
  localparam logic [2:0] ST_DRAIN = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_WAITM = 3'd3;
  localparam logic [2:0] ST_DIVV  = 3'd4;
  localparam logic [2:0] ST_SQRT  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // What a product is used for.
  localparam logic [2:0] TAG_SQ  = 3'd0;
  localparam logic [2:0] TAG_NQL = 3'd1;
  localparam logic [2:0] TAG_NQH = 3'd2;
  localparam logic [2:0] TAG_SS  = 3'd3;
  localparam logic [2:0] TAG_DEN = 3'd4;

  // Final multiply steps.
  localparam logic [1:0] STEP_NQL = 2'd0;
  localparam logic [1:0] STEP_NQH = 2'd1;
  localparam logic [1:0] STEP_SS  = 2'd2;
  localparam logic [1:0] STEP_DEN = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic [2:0] state;
  logic [1:0] step;

  // Running set state.
  logic [CNT_W-1:0]              count_acc;
  logic [SUM_W-1:0]              sum_acc;
  logic [SQ_W-1:0]               sq_acc;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic                          dropped;

  // Shared multiplier pipeline.
  logic              op_v;
  logic [MUL_W-1:0]  op_a;
  logic [MUL_W-1:0]  op_b;
  logic [2:0]        op_tag;
  logic              prod_v;
  logic [PROD_W-1:0] prod;
  logic [2:0]        prod_tag;

  // Final results under construction.
  logic [PROD_W-1:0] dacc;
  logic [DEN_W-1:0]  den_r;
  logic [MEAN_W-1:0] mean_q;
  logic [VAR_W-1:0]  var_q;

  // Output register.
  logic [CNT_W-1:0]       out_count;
  logic [MEAN_W-1:0]      out_mean;
  logic [VAR_W-1:0]       out_var;
  logic [ROOT_W-1:0]      out_sd;
  logic [SAMPLE_BITS-1:0] out_max;
  logic [SAMPLE_BITS-1:0] out_min;
  logic                   out_ovf;

  // Arithmetic units.
  logic              div_start;
  logic [ITER_W-1:0] div_iters;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  unit_stat_t        div_stat;
  logic [NUM_W-1:0]  div_quot;
  logic [DEN_W-1:0]  div_rem;
  logic              sqrt_start;
  unit_stat_t        sqrt_stat;
  logic [ROOT_W-1:0] sqrt_root;

  logic [SAMPLE_BITS-1:0]        sample_raw;
  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic [SAMPLE_BITS-1:0]        sample_mag;
  logic [SUM_W-1:0]              sample_ext;
  logic                          s_accept;
  logic                          room;
  logic [SUM_W-1:0]              sum_neg;
  logic [MAG_W-1:0]              sum_mag;
  logic                          sum_is_neg;
  logic                          pipe_empty;
  logic                          multi;
  logic                          round_up;
  logic [MEAN_W-1:0]             mean_mag;
  logic [MEAN_W-1:0]             mean_val;
  logic                          out_free;
  logic [CNT_W-1:0]              count_m1;

  // Input word decode.
  assign sample_raw = s_tdata[SAMPLE_BITS-1:0];
  assign sample_s   = signed'(sample_raw);
  assign sample_mag = sample_raw[SAMPLE_BITS-1] ? (~sample_raw) + 1'b1 : sample_raw;
  assign sample_ext = {{(SUM_W-SAMPLE_BITS){sample_raw[SAMPLE_BITS-1]}}, sample_raw};
  assign s_tready   = (state == ST_ACC);
  assign s_accept   = s_tvalid && s_tready;
  assign room       = (count_acc < CNT_W'(MAX_COUNT));

  // Magnitude and sign of the sum.
  assign sum_is_neg = sum_acc[SUM_W-1];
  assign sum_neg    = -sum_acc;
  assign sum_mag    = sum_is_neg ? sum_neg[MAG_W-1:0] : sum_acc[MAG_W-1:0];

  assign pipe_empty = !op_v && !prod_v;
  assign multi      = (count_acc > CNT_W'(1));
  assign out_free   = !m_tvalid || m_tready;
  assign count_m1   = count_acc - 1'b1;

  // Floor of the mean: a negative sum takes the ceiling of the magnitude.
  assign round_up = sum_is_neg && (div_rem != '0);
  assign mean_mag = div_quot[MEAN_W-1:0] + MEAN_W'(round_up);
  assign mean_val = sum_is_neg ? -mean_mag : mean_mag;

  // Divider and root unit operands and start pulses.
  always_comb begin
    div_start  = 1'b0;
    div_iters  = ITER_W'(MEAN_NUM_W);
    div_num    = {sum_mag, {(NUM_W-MAG_W){1'b0}}};
    div_den    = DEN_W'(count_acc);
    sqrt_start = 1'b0;
    unique case (state)
      ST_DRAIN: begin
        div_start = pipe_empty;
      end
      ST_WAITM: begin
        div_start = pipe_empty && !div_stat.busy && multi;
        div_iters = ITER_W'(NUM_W);
        div_num   = {dacc[D_W-1:0], {(2*FRAC_BITS){1'b0}}};
        div_den   = den_r;
      end
      ST_DIVV: begin
        sqrt_start = div_stat.done;
      end
      ST_ACC, ST_ISSUE, ST_SQRT, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Product register after the shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= op_v;
    end
    prod     <= op_a * op_b;
    prod_tag <= op_tag;
  end

  // Sequencer, accumulators and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      step      <= STEP_NQL;
      op_v      <= 1'b0;
      count_acc <= '0;
      sum_acc   <= '0;
      sq_acc    <= '0;
      run_max   <= SAMPLE_MIN;
      run_min   <= SAMPLE_MAX;
      dropped   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      op_v <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Products land in the accumulator their tag names.
      if (prod_v) begin
        case (prod_tag)
          TAG_SQ:  sq_acc <= sq_acc + SQ_W'(prod[2*SAMPLE_BITS-1:0]);
          TAG_NQL: dacc   <= prod;
          TAG_NQH: dacc   <= dacc + {prod[PROD_W-1-SQ_LO_W:0], {SQ_LO_W{1'b0}}};
          TAG_SS:  dacc   <= dacc - prod;
          TAG_DEN: den_r  <= prod[DEN_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_ACC: begin
          if (s_accept) begin
            if (room) begin
              count_acc <= count_acc + 1'b1;
              sum_acc   <= sum_acc + sample_ext;
              if (sample_s > run_max) run_max <= sample_s;
              if (sample_s < run_min) run_min <= sample_s;
              op_v   <= 1'b1;
              op_a   <= MUL_W'(sample_mag);
              op_b   <= MUL_W'(sample_mag);
              op_tag <= TAG_SQ;
            end else begin
              dropped <= 1'b1;
            end
            if (s_tlast) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // Wait for the last square to land; the mean division starts on leaving.
          if (pipe_empty) begin
            state <= ST_ISSUE;
            step  <= STEP_NQL;
          end
        end
        ST_ISSUE: begin
          // Build n*Q - S*S and n*(n-1) in four passes through the multiplier.
          op_v <= 1'b1;
          step <= step + 1'b1;
          unique case (step)
            STEP_NQL: begin
              op_a   <= MUL_W'(count_acc);
              op_b   <= MUL_W'(sq_acc[SQ_LO_W-1:0]);
              op_tag <= TAG_NQL;
            end
            STEP_NQH: begin
              op_a   <= MUL_W'(count_acc);
              op_b   <= MUL_W'(sq_acc[SQ_W-1:SQ_LO_W]);
              op_tag <= TAG_NQH;
            end
            STEP_SS: begin
              op_a   <= MUL_W'(sum_mag);
              op_b   <= MUL_W'(sum_mag);
              op_tag <= TAG_SS;
            end
            STEP_DEN: begin
              op_a   <= MUL_W'(count_acc);
              op_b   <= MUL_W'(count_m1);
              op_tag <= TAG_DEN;
              state  <= ST_WAITM;
            end
            default: begin
            end
          endcase
        end
        ST_WAITM: begin
          if (pipe_empty && !div_stat.busy) begin
            mean_q <= mean_val;
            if (multi) begin
              state <= ST_DIVV;
            end else begin
              var_q <= '0;
              state <= ST_DONE;
            end
          end
        end
        ST_DIVV: begin
          // The quotient carries sixteen fraction bits; the variance keeps eight.
          if (div_stat.done) begin
            var_q <= div_quot[VAR_W+FRAC_BITS-1:FRAC_BITS];
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sqrt_stat.done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_count <= count_acc;
            out_mean  <= mean_q;
            out_var   <= var_q;
            out_sd    <= multi ? sqrt_root : '0;
            out_max   <= run_max;
            out_min   <= run_min;
            out_ovf   <= dropped;
            count_acc <= '0;
            sum_acc   <= '0;
            sq_acc    <= '0;
            run_max   <= SAMPLE_MIN;
            run_min   <= SAMPLE_MAX;
            dropped   <= 1'b0;
            state     <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
    end
  end

  ssec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .iters (div_iters),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  ssec_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (div_quot[QV_W-1:0]),
    .stat  (sqrt_stat),
    .root  (sqrt_root)
  );

  // Result word.
  assign m_tdata = {7'b0, out_ovf, out_min, out_max, out_sd, out_var, out_mean, out_count};

  // Checks on the sequencing.
  `SSEC_ASSERT_IMPLIES(a_ready_units_idle, s_tready, !div_stat.busy && !sqrt_stat.busy, "input taken while a unit is busy")
  `SSEC_ASSERT_NEXT(a_last_closes_set, s_tvalid && s_tready && s_tlast, !s_tready, "input still taken after the last word")
  `SSEC_ASSERT_IMPLIES(a_single_zero_var, (state == ST_DONE) && (count_acc == CNT_W'(1)), var_q == '0, "single sample with nonzero variance")
  `SSEC_ASSERT_HOLDS(a_count_bound, count_acc <= CNT_W'(MAX_COUNT), "sample count beyond the set limit")

endmodule

`default_nettype wire

// ----- dv/stats_result_checker.sv -----
// Checker for the sample statistics engine: follows the sets on the input stream,
// computes each closed set's statistics and compares them with the output words.
// Depends on ssec_pkg for the field widths and the set size limit.
module stats_result_checker import ssec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [15:0]  s_tdata,        // [15:0] sample
  input  logic         s_tlast,        // last
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [143:0] m_tdata,        // statistics word, see set_stats_t
  output int unsigned  fail_count,
  output int unsigned  pending_count
);

  // Output word layout, lowest field last.
  typedef struct packed {
    logic [6:0]             pad;
    logic                   overflow;
    logic [SAMPLE_BITS-1:0] min_value;
    logic [SAMPLE_BITS-1:0] max_value;
    logic [ROOT_W-1:0]      stddev_q8;
    logic [VAR_W-1:0]       variance_q8;
    logic [MEAN_W-1:0]      mean_q8;
    logic [CNT_W-1:0]       sample_count;
  } set_stats_t;

  // Running state of the set in progress.
  int unsigned                   set_count;
  longint                        set_sum;
  longint unsigned               set_square_sum;
  logic signed [SAMPLE_BITS-1:0] set_max;
  logic signed [SAMPLE_BITS-1:0] set_min;
  logic                          set_dropped;

  // Statistics of closed sets that have not come out yet, oldest first.
  set_stats_t stats_due[$];

  function automatic void clear_set();
    set_count      = 0;
    set_sum        = 0;
    set_square_sum = 0;
    set_max        = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    set_min        = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    set_dropped    = 1'b0;
  endfunction

  // Appends a closed set's statistics behind the ones already waiting.
  function automatic void queue_stats(set_stats_t s);
    stats_due.insert(stats_due.size(), s);
  endfunction

  // Exact statistics of the current set, floored to the fixed-point format.
  function automatic set_stats_t compute_set_stats();
    set_stats_t   r;
    longint       scaled_sum;
    longint       mean;
    logic [127:0] mag, spread, pairs, var_fine, var_scaled, root, trial;
    r = '0;
    scaled_sum = set_sum * (longint'(1) << FRAC_BITS);
    mean = scaled_sum / longint'(set_count);
    // Division truncates toward zero, so an inexact negative quotient steps down once.
    if (scaled_sum < 0 && scaled_sum % longint'(set_count) != 0) begin
      mean = mean - 1;
    end
    r.sample_count = set_count[CNT_W-1:0];
    r.mean_q8      = mean[MEAN_W-1:0];
    r.max_value    = set_max;
    r.min_value    = set_min;
    r.overflow     = set_dropped;
    // A single sample has no spread; otherwise (n*Q - S*S) / (n*(n-1)).
    if (set_count > 1) begin
      mag        = 128'(set_sum < 0 ? -set_sum : set_sum);
      spread     = 128'(set_count) * 128'(set_square_sum) - mag * mag;
      pairs      = 128'(set_count) * 128'(set_count - 1);
      var_fine   = (spread << FRAC_BITS) / pairs;
      var_scaled = (spread << (2 * FRAC_BITS)) / pairs;
      r.variance_q8 = var_fine[VAR_W-1:0];
      // Integer square root, one bit at a time from the top.
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (128'(1) << b);
        if (trial * trial <= var_scaled) begin
          root = trial;
        end
      end
      r.stddev_q8 = root[ROOT_W-1:0];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Input words update the set; output words are checked against the oldest set.
  always @(posedge clk) begin : track
    set_stats_t                    got;
    set_stats_t                    want;
    logic signed [SAMPLE_BITS-1:0] smp;
    if (rst) begin
      clear_set();
      stats_due.delete();
      fail_count = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        smp = s_tdata;
        if (set_count < MAX_COUNT) begin
          set_count++;
          set_sum += smp;
          set_square_sum += longint'(smp) * longint'(smp);
          if (smp > set_max) begin
            set_max = smp;
          end
          if (smp < set_min) begin
            set_min = smp;
          end
        end else begin
          set_dropped = 1'b1;
        end
        if (s_tlast) begin
          queue_stats(compute_set_stats());
          clear_set();
        end
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (stats_due.size() == 0) begin
          $display("%0t: result word with no set closed, expected none, actual %h",
                   $time, m_tdata);
          fail_count++;
        end else begin
          want = stats_due.pop_front();
          check_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
          check_field("mean_q8", 64'(want.mean_q8), 64'(got.mean_q8));
          check_field("variance_q8", 64'(want.variance_q8), 64'(got.variance_q8));
          check_field("stddev_q8", 64'(want.stddev_q8), 64'(got.stddev_q8));
          check_field("max_value", 64'(want.max_value), 64'(got.max_value));
          check_field("min_value", 64'(want.min_value), 64'(got.min_value));
          check_field("overflow", 64'(want.overflow), 64'(got.overflow));
          check_field("padding", 64'(want.pad), 64'(got.pad));
        end
      end
    end
    pending_count = stats_due.size();
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the sample statistics engine: clock, reset, input sets and
// output back-pressure. Depends on ssec_pkg, the engine and stats_result_checker.
module tb import ssec_pkg::*;;

  localparam int QUIET_LIMIT = 20000;

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [15:0]  s_tdata  = '0;     // [15:0] sample
  logic         s_tlast  = 1'b0;   // last
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [143:0] m_tdata;           // statistics word

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_len      = 0;
  int unsigned quiet_cycles  = 0;

  sample_statistics_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  stats_result_checker scoreboard (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin : sink
    int unsigned span;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        span = hold_len;
        hold_len = 0;
        m_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither side moves a word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one word and returns at the edge that takes it; valid stays high.
  task automatic send_word(input logic [15:0] smp, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly full-range values, with the extremes and values near zero weighted up.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($signed($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly short sets, now and then a longer one.
  function automatic int pick_size();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(1, 4);
      6, 7, 8:          return $urandom_range(5, 16);
      default:          return $urandom_range(17, 60);
    endcase
  endfunction

  task automatic send_set(input int size);
    for (int i = 0; i < size; i++) begin
      send_word(pick_sample(), i == size - 1);
    end
  endtask

  // Drops valid and waits until every closed set has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  initial begin : stimulus
    int sent;
    int size;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-sample sets at both extremes.
    send_word(16'h7fff, 1'b1);
    send_word(16'h8000, 1'b1);
    // Negative mean that is not exact: -1/3 floors downward.
    send_word(16'hffff, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h0000, 1'b1);
    // Widest spread from two samples.
    send_word(16'h8000, 1'b0);
    send_word(16'h7fff, 1'b1);
    // Equal samples give zero variance.
    send_word(16'h0005, 1'b0);
    send_word(16'h0005, 1'b0);
    send_word(16'h0005, 1'b1);
    // Most negative and most positive means.
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b1);
    send_word(16'h7fff, 1'b0);
    send_word(16'h7fff, 1'b1);
    // Small negative sum with a remainder, in a mixed set.
    send_word(16'hfffe, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'hfffb, 1'b1);
    drain();

    // Random sets under each mix of idling on the two sides.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 49; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      sent = 0;
      while (sent < 120) begin
        size = pick_size();
        send_set(size);
        sent += size;
      end
      drain();
    end

    // Long receiver hold-off while sets keep coming, so the input backs up.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 3000;
    for (int k = 0; k < 6; k++) begin
      send_set($urandom_range(1, 8));
    end
    drain();

    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sample_statistics_engine_core.f -----
+incdir+sv
sv/ssec_pkg.sv
sv/ssec_div.sv
sv/ssec_sqrt.sv
sv/sample_statistics_engine_core.sv
dv/stats_result_checker.sv
dv/tb.sv
